### design/kscl_pkg.sv
`timescale 1ns / 1ps

package kscl_pkg;

    typedef struct packed {
        logic [15:0] pin_code;
        logic [7:0]  settle_ticks;
        logic [7:0]  debounce_ticks;
        logic [15:0] unlock_ticks;
    } kscl_cfg_t;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_seen;
        logic [3:0] key_position;
        logic       access_granted;
        logic       access_denied;
        logic       too_many_digits;
        logic       door_unlocked;
    } kscl_res_t;

endpackage

### design/keypad_scan_code_lock.sv
`timescale 1ns / 1ps
// A tick is taken into the input register and, once the result register is free or being
//   drained, processed into the result register, which raises out_valid.
// Throughput: one tick per cycle while results are drained; the scan state machine updates once per tick.
// Reset (rst_n, asynchronous, active low): settling on row zero, counters and entry cleared,
//   registers back to code 1234, settle 10, debounce 50, unlock 1000; no clearing pass.
module keypad_scan_code_lock
#(
    parameter int CODE_DIGITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  col_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  row_drive,
    output logic        key_seen,
    output logic [3:0]  key_position,
    output logic        access_granted,
    output logic        access_denied,
    output logic        too_many_digits,
    output logic        door_unlocked
);
    import kscl_pkg::*;

    kscl_cfg_t  cfg;
    kscl_res_t  res;
    kscl_res_t  res_reg;
    logic       in_valid_reg;
    logic [3:0] cols_reg;
    logic       out_valid_reg;
    logic       step;

    // Advance the held tick whenever the result register is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    kscl_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kscl_fsm #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cols  (cols_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cols_reg <= col_levels;
        if (step)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign row_drive       = res_reg.row_drive;
    assign key_seen        = res_reg.key_seen;
    assign key_position    = res_reg.key_position;
    assign access_granted  = res_reg.access_granted;
    assign access_denied   = res_reg.access_denied;
    assign too_many_digits = res_reg.too_many_digits;
    assign door_unlocked   = res_reg.door_unlocked;

endmodule

### design/kscl_regs.sv
`timescale 1ns / 1ps

module kscl_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output kscl_pkg::kscl_cfg_t cfg
);
    import kscl_pkg::*;

    localparam logic [1:0] REG_PIN_CODE = 2'd0;
    localparam logic [1:0] REG_SETTLE   = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;
    localparam logic [1:0] REG_UNLOCK   = 2'd3;

    kscl_cfg_t  cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_code       <= 16'h1234;
            cfg_reg.settle_ticks   <= 8'd10;
            cfg_reg.debounce_ticks <= 8'd50;
            cfg_reg.unlock_ticks   <= 16'd1000;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_PIN_CODE: cfg_reg.pin_code       <= pwdata[15:0];
                REG_SETTLE:   cfg_reg.settle_ticks   <= pwdata[7:0];
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= pwdata[7:0];
                REG_UNLOCK:   cfg_reg.unlock_ticks   <= pwdata[15:0];
                default:      cfg_reg.pin_code       <= cfg_reg.pin_code;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PIN_CODE: prdata = {16'd0, cfg_reg.pin_code};
            REG_SETTLE:   prdata = {24'd0, cfg_reg.settle_ticks};
            REG_DEBOUNCE: prdata = {24'd0, cfg_reg.debounce_ticks};
            REG_UNLOCK:   prdata = {16'd0, cfg_reg.unlock_ticks};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

### design/kscl_fsm.sv
`timescale 1ns / 1ps

module kscl_fsm
#(
    parameter int CODE_DIGITS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [3:0]          cols,
    input  kscl_pkg::kscl_cfg_t cfg,
    output kscl_pkg::kscl_res_t res
);
    import kscl_pkg::*;

    localparam int CNT_W = $clog2(CODE_DIGITS + 1);
    localparam int PIN_W = (4 * CODE_DIGITS > 16) ? 4 * CODE_DIGITS : 16;

    localparam logic [2:0] PH_SETTLE  = 3'd0;
    localparam logic [2:0] PH_CHECK   = 3'd1;
    localparam logic [2:0] PH_PRESS   = 3'd2;
    localparam logic [2:0] PH_HOLD    = 3'd3;
    localparam logic [2:0] PH_RELWAIT = 3'd4;
    localparam logic [2:0] PH_RELDB   = 3'd5;

    localparam logic [3:0] KEY_HASH = 4'd14;
    localparam logic [3:0] KEY_NONE = 4'd15;

    // Key meaning by row*4+col: digits, hash, or nothing
    function automatic logic [3:0] key_kind(input logic [3:0] pos);
        logic [3:0] kind;
        case (pos)
            4'd0:    kind = 4'd1;
            4'd1:    kind = 4'd2;
            4'd2:    kind = 4'd3;
            4'd4:    kind = 4'd4;
            4'd5:    kind = 4'd5;
            4'd6:    kind = 4'd6;
            4'd8:    kind = 4'd7;
            4'd9:    kind = 4'd8;
            4'd10:   kind = 4'd9;
            4'd13:   kind = 4'd0;
            4'd14:   kind = KEY_HASH;
            default: kind = KEY_NONE;
        endcase
        return kind;
    endfunction

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       scan_row_reg, scan_row_next;
    logic [1:0]       scan_col_reg, scan_col_next;
    logic [15:0]      wait_count_reg, wait_count_next;
    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    logic [3:0]       digit_store_reg [CODE_DIGITS];
    logic [3:0]       digit_store_next [CODE_DIGITS];

    logic [15:0]      wc_inc;
    logic [PIN_W-1:0] pin_ext;
    logic             entry_ok;
    logic             col_hit;
    logic [1:0]       col_sel;
    logic [3:0]       pos;
    logic [3:0]       kind;

    assign wc_inc  = wait_count_reg + 16'd1;
    assign pin_ext = PIN_W'(cfg.pin_code);
    assign pos     = {scan_row_reg, scan_col_reg};
    assign kind    = key_kind(pos);

    always_comb
    begin
        entry_ok = (digit_count_reg == CNT_W'(CODE_DIGITS));
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (digit_store_reg[i] != pin_ext[4 * (CODE_DIGITS - 1 - i) +: 4])
                entry_ok = 1'b0;
        end
    end

    // Lowest pressed column at or after the current column
    always_comb
    begin
        col_hit = 1'b0;
        col_sel = 2'd0;
        for (int c = 3; c >= 0; c--)
        begin
            if ((2'(c) >= scan_col_reg) && !cols[c])
            begin
                col_hit = 1'b1;
                col_sel = 2'(c);
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        scan_row_next    = scan_row_reg;
        scan_col_next    = scan_col_reg;
        wait_count_next  = wait_count_reg;
        digit_count_next = digit_count_reg;
        digit_store_next = digit_store_reg;

        res                 = '0;
        res.row_drive       = ~(4'b0001 << scan_row_reg);

        case (phase_reg)
            PH_SETTLE:
            begin
                wait_count_next = wc_inc;
                if (wc_inc >= {8'd0, cfg.settle_ticks})
                begin
                    wait_count_next = 16'd0;
                    phase_next      = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                wait_count_next = 16'd0;
                if (col_hit)
                begin
                    scan_col_next = col_sel;
                    phase_next    = PH_PRESS;
                end
                else
                begin
                    scan_row_next = scan_row_reg + 2'd1;
                    scan_col_next = 2'd0;
                    phase_next    = PH_SETTLE;
                end
            end
            PH_PRESS:
            begin
                wait_count_next = wc_inc;
                if (wc_inc >= {8'd0, cfg.debounce_ticks})
                begin
                    wait_count_next  = 16'd0;
                    res.key_seen     = 1'b1;
                    res.key_position = pos;
                    phase_next       = PH_RELWAIT;
                    if (kind == KEY_HASH)
                    begin
                        if (entry_ok)
                        begin
                            res.access_granted = 1'b1;
                            phase_next         = PH_HOLD;
                        end
                        else
                        begin
                            res.access_denied = 1'b1;
                        end
                        digit_count_next = '0;
                    end
                    else if (kind <= 4'd9)
                    begin
                        if (digit_count_reg < CNT_W'(CODE_DIGITS))
                        begin
                            for (int i = 0; i < CODE_DIGITS; i++)
                            begin
                                if (digit_count_reg == CNT_W'(i))
                                    digit_store_next[i] = kind;
                            end
                            digit_count_next = digit_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            res.too_many_digits = 1'b1;
                            digit_count_next    = '0;
                        end
                    end
                end
            end
            PH_HOLD:
            begin
                res.door_unlocked = 1'b1;
                wait_count_next   = wc_inc;
                if (wc_inc >= cfg.unlock_ticks)
                begin
                    wait_count_next = 16'd0;
                    phase_next      = PH_RELWAIT;
                end
            end
            PH_RELWAIT:
            begin
                if (cols[scan_col_reg])
                begin
                    wait_count_next = 16'd0;
                    phase_next      = PH_RELDB;
                end
            end
            PH_RELDB:
            begin
                wait_count_next = wc_inc;
                if (wc_inc >= {8'd0, cfg.debounce_ticks})
                begin
                    wait_count_next = 16'd0;
                    if (scan_col_reg == 2'd3)
                    begin
                        scan_row_next = scan_row_reg + 2'd1;
                        scan_col_next = 2'd0;
                        phase_next    = PH_SETTLE;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + 2'd1;
                        phase_next    = PH_CHECK;
                    end
                end
            end
            default:
            begin
                scan_col_next   = 2'd0;
                wait_count_next = 16'd0;
                phase_next      = PH_SETTLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SETTLE;
            scan_row_reg    <= 2'd0;
            scan_col_reg    <= 2'd0;
            wait_count_reg  <= 16'd0;
            digit_count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            scan_row_reg    <= scan_row_next;
            scan_col_reg    <= scan_col_next;
            wait_count_reg  <= wait_count_next;
            digit_count_reg <= digit_count_next;
        end
    end

    // Digits are only compared once all of them have been written since the last clear
    always_ff @(posedge clk)
    begin
        if (step)
            digit_store_reg <= digit_store_next;
    end

endmodule

### design/kscl_checker.sv
`timescale 1ns / 1ps

module kscl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] row_drive,
    input logic       key_seen,
    input logic [3:0] key_position,
    input logic       access_granted,
    input logic       access_denied,
    input logic       too_many_digits
);

    // A stalled result transaction holds its valid, row drive and key position
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_drive) && $stable(key_position))
        else $error("result changed while stalled");

    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(~row_drive))
        else $error("row drive not a single low row");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(access_granted && access_denied))
        else $error("grant and deny together");

    a_flag_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access_granted || access_denied || too_many_digits) |-> key_seen)
        else $error("entry flag without a taken key");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_seen |-> key_position == 4'd0)
        else $error("key position set without a key");

endmodule

bind keypad_scan_code_lock kscl_checker u_kscl_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .row_drive       (row_drive),
    .key_seen        (key_seen),
    .key_position    (key_position),
    .access_granted  (access_granted),
    .access_denied   (access_denied),
    .too_many_digits (too_many_digits)
);
